[design/qau_pkg.sv]
`default_nettype none
package qau_pkg;
   localparam int CompWidth = 32;
   localparam int FracBits = 28;
   localparam int Lanes = 4;

   typedef enum logic [1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_MUL  = 2'd1,
      FUNC_CONJ = 2'd2,
      FUNC_NORM = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_SAT  = 2'd1,
      STAT_ZERO = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUMSQ,
      ST_SQRT,
      ST_DIV,
      ST_DONE
   } state_type;

   // Sign patterns and operand selection for the Hamilton product:
   // lane L, term T multiplies held[T] by operand[ham_sel(L,T)].
   function automatic logic [1:0] ham_sel(input logic [1:0] lane, input logic [1:0] term);
      logic [1:0] r;
      r = lane ^ term;
      return r;
   endfunction

   function automatic logic ham_neg(input logic [1:0] lane, input logic [1:0] term);
      logic [15:0] tbl;
      // bit index lane*4+term; 1 means subtract
      // w: + - - -   i: + + + -   j: + - + +   k: + + - +
      tbl = 16'b0100_0010_1000_1110;
      return tbl[{lane, term}];
   endfunction
endpackage
`default_nettype wire

[design/qau_lane.sv]
`default_nettype none
// One lane: accumulates products for one component, then runs a
// restoring divide of |c|*2^F by the root for normalize.
module qau_lane #(
   parameter int CW = qau_pkg::CompWidth,
   parameter int FB = qau_pkg::FracBits
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   acc_clear,
   input  wire logic                   acc_en,
   input  wire logic signed [CW-1:0]   mul_a,
   input  wire logic signed [CW-1:0]   mul_b,
   input  wire logic                   mul_neg,
   input  wire logic                   div_start,
   input  wire logic                   div_step,
   input  wire logic signed [CW-1:0]   div_num,
   input  wire logic [CW:0]            div_den,
   output logic signed [2*CW+2:0]      acc,
   output logic signed [CW+FB:0]       quot
);
   import qau_pkg::*;
   localparam int AW = 2*CW + 3;
   localparam int NW = CW + FB;
   localparam int RW = CW + 2;

   logic signed [2*CW-1:0] prod_ff, prod_in;
   logic                   pv_ff, pn_ff;
   logic signed [AW-1:0]   acc_ff, acc_in;
   logic [NW-1:0]          num_ff, num_in;
   logic [NW-1:0]          q_ff, q_in;
   logic [RW-1:0]          rem_ff, rem_in;
   logic                   sign_ff, sign_in;
   logic [RW-1:0]          trial;
   logic [CW-1:0]          mag_c;

   assign prod_in = mul_a * mul_b;
   assign mag_c = div_num[CW-1] ? CW'(-div_num) : CW'(div_num);

   always_comb begin
      acc_in = acc_ff;
      if (acc_clear) begin
         acc_in = '0;
      end else if (pv_ff) begin
         acc_in = pn_ff ? acc_ff - AW'(prod_ff) : acc_ff + AW'(prod_ff);
      end
   end

   always_comb begin
      num_in = num_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      sign_in = sign_ff;
      trial = {rem_ff[RW-2:0], num_ff[NW-1]} - RW'(div_den);
      if (div_start) begin
         num_in = {mag_c, FB'(0)};
         q_in = '0;
         rem_in = '0;
         sign_in = div_num[CW-1];
      end else if (div_step) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (!trial[RW-1]) begin
            rem_in = trial;
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[RW-2:0], num_ff[NW-1]};
            q_in = {q_ff[NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= acc_en;
      end
      pn_ff <= mul_neg;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      num_ff <= num_in;
      q_ff <= q_in;
      rem_ff <= rem_in;
      sign_ff <= sign_in;
   end

   assign acc = acc_ff;
   assign quot = sign_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
endmodule
`default_nettype wire

[design/qau_sqrt.sv]
`default_nettype none
// Bit-serial integer square root, one result bit per cycle while step is high.
module qau_sqrt #(
   parameter int CW = qau_pkg::CompWidth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              step,
   input  wire logic [2*CW+1:0]   radicand,
   output logic [CW:0]            root
);
   import qau_pkg::*;
   localparam int SW = 2*CW + 2;
   localparam int QW = CW + 1;

   logic [SW-1:0] rad_ff, rad_in;
   logic [SW+1:0] rem_ff, rem_in;
   logic [QW-1:0] q_ff, q_in;
   logic [SW+1:0] shifted, trial;

   always_comb begin
      rad_in = rad_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      shifted = {rem_ff[SW-1:0], rad_ff[SW-1:SW-2]};
      trial = shifted - (SW+2)'({q_ff, 2'b01});
      if (start) begin
         rad_in = radicand;
         rem_in = '0;
         q_in = '0;
      end else if (step) begin
         rad_in = {rad_ff[SW-3:0], 2'b00};
         if (!trial[SW+1]) begin
            rem_in = trial;
            q_in = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in = {q_ff[QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
      rad_ff <= rad_in;
      rem_ff <= rem_in;
   end

   assign root = q_ff;
endmodule
`default_nettype wire

[design/quaternion_attitude_unit_top.sv]
`default_nettype none
// Quaternion attitude unit. Holds one quaternion, identity after reset.
// Requests arrive on req_ (tdata: func, operand_w, operand_i, operand_j,
// operand_k from bit 0 up); each returns the held quaternion and a status
// on rsp_ (tdata: result_w, result_i, result_j, result_k, status).
// One request is worked on at a time; req_tready is low while busy and
// while a result waits for the receiver, which may stall freely.
// Load and conjugate go straight to the final state; multiply uses four
// lanes, one multiplier each, with the four terms in turn; normalize
// forms the sum of squares, then the square root, then the divide in
// all four lanes at once, and ends in the final state. A zero norm
// skips the divide.
// The next request is taken in the cycle after the result handshake.
// Reset is synchronous and restores the identity quaternion.
module quaternion_attitude_unit_top #(
   parameter int COMPONENT_WIDTH = qau_pkg::CompWidth,
   parameter int FRACTION_BITS = qau_pkg::FracBits
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // func, operand_w, operand_i, operand_j, operand_k from bit 0
   input  wire logic [((4*COMPONENT_WIDTH+2+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // result_w, result_i, result_j, result_k, status from bit 0
   output logic [((4*COMPONENT_WIDTH+2+7)/8)*8-1:0] rsp_tdata
);
   import qau_pkg::*;
   localparam int CW = COMPONENT_WIDTH;
   localparam int FB = FRACTION_BITS;
   localparam int AW = 2*CW + 3;
   localparam int QW = CW + FB + 1;
   localparam int SQW = CW + 1;
   localparam int DIVN = CW + FB;
   localparam int CNTW = $clog2(DIVN + 1) + 1;
   localparam logic signed [CW-1:0] MaxV = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] MinV = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] OneV = (FB <= CW-2) ? CW'(1) << FB : MaxV;

   state_type state_ff, state_in;
   logic signed [CW-1:0] held_ff [Lanes], held_in [Lanes];
   logic signed [CW-1:0] opnd_ff [Lanes], opnd_in [Lanes];
   func_type func_ff, func_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [1:0] stat_ff, stat_in;
   logic rv_ff, rv_in;

   logic signed [CW-1:0] mul_a [Lanes], mul_b [Lanes];
   logic mul_neg [Lanes];
   logic signed [AW-1:0] acc [Lanes];
   logic signed [QW-1:0] quot [Lanes];
   logic acc_clear, acc_en, div_start, div_step, sq_start, sq_step;
   logic [SQW-1:0] root;
   logic [2*CW+1:0] sumsq;
   logic accept;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;

   function automatic logic signed [CW-1:0] sat_acc(input logic signed [AW-1:0] v,
                                                     output logic s);
      logic signed [AW-1:0] t;
      t = v >>> FB;
      s = 1'b0;
      if (t > AW'(MaxV)) begin
         s = 1'b1;
         return MaxV;
      end else if (t < AW'(MinV)) begin
         s = 1'b1;
         return MinV;
      end
      return CW'(t);
   endfunction

   function automatic logic signed [CW-1:0] sat_q(input logic signed [QW-1:0] v,
                                                   output logic s);
      s = 1'b0;
      if (v > QW'(MaxV)) begin
         s = 1'b1;
         return MaxV;
      end else if (v < QW'(MinV)) begin
         s = 1'b1;
         return MinV;
      end
      return CW'(v);
   endfunction

   assign sumsq = (2*CW+2)'(acc[0]);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func_type'(req_tdata[1:0]))
                  FUNC_MUL:  state_in = ST_MUL;
                  FUNC_NORM: state_in = ST_SUMSQ;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_MUL:   if (cnt_ff == CNTW'(5)) state_in = ST_DONE;
         ST_SUMSQ: if (cnt_ff == CNTW'(5)) state_in = ST_SQRT;
         ST_SQRT:  if (cnt_ff == CNTW'(SQW)) state_in = (root == '0) ? ST_DONE : ST_DIV;
         ST_DIV:   if (cnt_ff == CNTW'(DIVN)) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath control and updates
   always_comb begin
      logic s0, s1, s2, s3;
      logic signed [CW-1:0] v0, v1, v2, v3;
      held_in = held_ff;
      opnd_in = opnd_ff;
      func_in = func_ff;
      cnt_in = cnt_ff;
      stat_in = stat_ff;
      rv_in = rv_ff;
      acc_clear = 1'b0;
      acc_en = 1'b0;
      div_start = 1'b0;
      div_step = 1'b0;
      sq_start = 1'b0;
      sq_step = 1'b0;
      s0 = 1'b0; s1 = 1'b0; s2 = 1'b0; s3 = 1'b0;
      v0 = '0; v1 = '0; v2 = '0; v3 = '0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      for (int l = 0; l < Lanes; l++) begin
         mul_a[l] = held_ff[cnt_ff[1:0]];
         mul_b[l] = opnd_ff[ham_sel(2'(l), cnt_ff[1:0])];
         mul_neg[l] = ham_neg(2'(l), cnt_ff[1:0]);
      end
      if (state_ff == ST_SUMSQ) begin
         for (int l = 0; l < Lanes; l++) begin
            mul_a[l] = held_ff[cnt_ff[1:0]];
            mul_b[l] = held_ff[cnt_ff[1:0]];
            mul_neg[l] = 1'b0;
         end
      end
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            acc_clear = 1'b1;
            if (accept) begin
               func_in = func_type'(req_tdata[1:0]);
               for (int l = 0; l < Lanes; l++) begin
                  opnd_in[l] = req_tdata[2+l*CW +: CW];
               end
               stat_in = STAT_OK;
            end
         end
         ST_MUL, ST_SUMSQ: begin
            cnt_in = cnt_ff + 1'b1;
            acc_en = (cnt_ff < CNTW'(4));
            if (cnt_ff == CNTW'(5)) begin
               cnt_in = '0;
               sq_start = 1'b1;
               if (state_ff == ST_MUL) begin
                  v0 = sat_acc(acc[0], s0);
                  v1 = sat_acc(acc[1], s1);
                  v2 = sat_acc(acc[2], s2);
                  v3 = sat_acc(acc[3], s3);
                  held_in[0] = v0; held_in[1] = v1;
                  held_in[2] = v2; held_in[3] = v3;
                  if (s0 || s1 || s2 || s3) stat_in = STAT_SAT;
               end
            end
         end
         ST_SQRT: begin
            cnt_in = cnt_ff + 1'b1;
            sq_step = 1'b1;
            if (cnt_ff == CNTW'(SQW)) begin
               sq_step = 1'b0;
               cnt_in = '0;
               div_start = 1'b1;
               if (root == '0) stat_in = STAT_ZERO;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            div_step = 1'b1;
            if (cnt_ff == CNTW'(DIVN)) begin
               div_step = 1'b0;
               v0 = sat_q(quot[0], s0);
               v1 = sat_q(quot[1], s1);
               v2 = sat_q(quot[2], s2);
               v3 = sat_q(quot[3], s3);
               held_in[0] = v0; held_in[1] = v1;
               held_in[2] = v2; held_in[3] = v3;
               if (s0 || s1 || s2 || s3) stat_in = STAT_SAT;
            end
         end
         ST_DONE: begin
            rv_in = 1'b1;
            if (func_ff == FUNC_LOAD) begin
               held_in = opnd_ff;
            end else if (func_ff == FUNC_CONJ) begin
               for (int l = 1; l < Lanes; l++) begin
                  if (held_ff[l] == MinV) begin
                     held_in[l] = MaxV;
                     stat_in = STAT_SAT;
                  end else begin
                     held_in[l] = -held_ff[l];
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         cnt_ff <= '0;
         held_ff[0] <= OneV;
         held_ff[1] <= '0;
         held_ff[2] <= '0;
         held_ff[3] <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         cnt_ff <= cnt_in;
         held_ff <= held_in;
      end
      opnd_ff <= opnd_in;
      func_ff <= func_in;
      stat_ff <= stat_in;
   end

   for (genvar l = 0; l < Lanes; l++) begin : g_lane
      qau_lane #(.CW(CW), .FB(FB)) u_lane (
         .clock(clock), .reset(reset),
         .acc_clear(acc_clear), .acc_en(acc_en),
         .mul_a(mul_a[l]), .mul_b(mul_b[l]), .mul_neg(mul_neg[l]),
         .div_start(div_start), .div_step(div_step),
         .div_num(held_ff[l]), .div_den(root),
         .acc(acc[l]), .quot(quot[l])
      );
   end

   qau_sqrt #(.CW(CW)) u_sqrt (
      .clock(clock), .reset(reset),
      .start(sq_start && state_ff == ST_SUMSQ), .step(sq_step),
      .radicand(sumsq), .root(root)
   );

   assign rsp_tvalid = rv_ff;
   always_comb begin
      rsp_tdata = '0;
      for (int l = 0; l < Lanes; l++) begin
         rsp_tdata[l*CW +: CW] = held_ff[l];
      end
      rsp_tdata[4*CW +: 2] = stat_ff;
   end

`ifndef SYNTHESIS
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_tvalid) else $error("no result");
`endif
endmodule
`default_nettype wire
